>>> hw/rtl/sysres_pkg.sv
`default_nettype none
package sysres_pkg;

    localparam int COUNT_W        = 11;
    localparam int SOURCE_INDEX_W = 10;
    localparam int CFG_INDEX_W    = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_PARTICLE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE         = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET  = 11'd1024;
    localparam int                 STRIDE_RESET = 16384;

endpackage
`default_nettype wire

>>> hw/rtl/sysres_ram.sv
`default_nettype none
module sysres_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/systematic_resampler_core.sv
`default_nettype none
// Systematic resampler. Load transactions (mode 0) take one weight each,
// without leaving the idle state; the running cumulative sum is written to
// the sum memory. Once particle_count weights are in, draw transactions
// (mode 1) each return the source index of the next resampled particle, the
// final draw of a pass flagged by last. A draw steps the walk pointer over
// the sum memory: each step is one registered read of the sum memory
// followed by one compare. Over a pass the pointer steps at most count-1
// times. A transaction in the wrong phase returns status 1 and changes
// nothing. The input side stalls while a draw is in progress or a result
// waits to enter the output register. No clearing is needed after reset.
module systematic_resampler_core #(
    parameter int MAX_PARTICLES        = 1024,
    parameter int WEIGHT_FRACTION_BITS = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [sysres_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [((WEIGHT_FRACTION_BITS+1 > sysres_pkg::COUNT_W) ?
                         WEIGHT_FRACTION_BITS+1 : sysres_pkg::COUNT_W)-1:0] i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_mode,
    input  wire logic [WEIGHT_FRACTION_BITS:0]     i_weight,
    input  wire logic [WEIGHT_FRACTION_BITS-1:0]   i_offset,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [sysres_pkg::SOURCE_INDEX_W-1:0]  o_source_index,
    output logic                                   o_last,
    output logic                                   o_status
);
    import sysres_pkg::*;

    localparam int SumW  = WEIGHT_FRACTION_BITS + 2;
    localparam int StrW  = WEIGHT_FRACTION_BITS + 1;
    localparam int CntW  = $clog2(MAX_PARTICLES + 1);
    localparam int AddrW = $clog2(MAX_PARTICLES);
    localparam int CmpW  = (CntW > COUNT_W) ? CntW : COUNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]          r_state,   n_state;
    logic [COUNT_W-1:0]  r_pcount,  n_pcount;
    logic [StrW-1:0]     r_stride,  n_stride;
    logic [SumW-1:0]     r_sum,     n_sum;
    logic [CntW-1:0]     r_ld_cnt,  n_ld_cnt;
    logic [CntW-1:0]     r_dr_cnt,  n_dr_cnt;
    logic [AddrW-1:0]    r_ptr,     n_ptr;
    logic [SumW-1:0]     r_thr,     n_thr;
    logic                r_out_valid, n_out_valid;
    logic [AddrW-1:0]    r_res_idx, n_res_idx;
    logic                r_res_last, n_res_last;
    logic                r_res_status, n_res_status;
    logic [AddrW-1:0]    r_out_idx, n_out_idx;
    logic                r_out_last, n_out_last;
    logic                r_out_status, n_out_status;

    logic [CmpW-1:0]     pc_ext;
    logic [CntW-1:0]     cnt;
    logic [AddrW-1:0]    cnt_m1;
    logic                loading;
    logic                accept;
    logic                is_last;
    logic [SumW:0]       add_a;
    logic [SumW:0]       add_b;
    logic [SumW:0]       add_s;
    logic [SumW-1:0]     add_sat;
    logic                ram_we;
    logic [SumW-1:0]     ram_rdata;
    logic [AddrW+SOURCE_INDEX_W-1:0] idx_ext;

    sysres_ram #(
        .WIDTH(SumW),
        .DEPTH(MAX_PARTICLES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_ld_cnt[AddrW-1:0]),
        .i_wdata(add_sat),
        .i_raddr(r_ptr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        pc_ext = CmpW'(r_pcount);
        if (pc_ext == '0) begin
            cnt = CntW'(1);
        end else if (pc_ext > CmpW'(MAX_PARTICLES)) begin
            cnt = CntW'(MAX_PARTICLES);
        end else begin
            cnt = CntW'(pc_ext);
        end
        cnt_m1  = AddrW'(cnt - CntW'(1));
        loading = (r_ld_cnt < cnt);
        is_last = ({1'b0, r_dr_cnt} + (CntW+1)'(1)) >= {1'b0, cnt};
    end

    // one shared saturating adder: load sum or threshold step
    always_comb begin
        add_a = {1'b0, (i_mode == MODE_LOAD) ? r_sum : r_thr};
        add_b = (i_mode == MODE_LOAD) ? (SumW+1)'(i_weight) : (SumW+1)'(r_stride);
        add_s = add_a + add_b;
        add_sat = add_s[SumW] ? '1 : add_s[SumW-1:0];
    end

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign ram_we = accept && (i_mode == MODE_LOAD) && loading;

    always_comb begin
        n_state      = r_state;
        n_pcount     = r_pcount;
        n_stride     = r_stride;
        n_sum        = r_sum;
        n_ld_cnt     = r_ld_cnt;
        n_dr_cnt     = r_dr_cnt;
        n_ptr        = r_ptr;
        n_thr        = r_thr;
        n_res_idx    = r_res_idx;
        n_res_last   = r_res_last;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PARTICLE_COUNT: n_pcount = i_cfg_data[COUNT_W-1:0];
                CFG_STRIDE:         n_stride = i_cfg_data[StrW-1:0];
                default:            ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_LOAD && loading) begin
                        n_sum    = add_sat;
                        n_ld_cnt = r_ld_cnt + CntW'(1);
                    end else if (i_mode == MODE_DRAW && !loading) begin
                        if (r_dr_cnt == '0) begin
                            n_thr = SumW'(i_offset);
                            n_ptr = '0;
                        end else begin
                            n_thr = add_sat;
                            n_ptr = (r_ptr > cnt_m1) ? cnt_m1 : r_ptr;
                        end
                        n_state = S_READ;
                    end else begin
                        n_res_idx    = '0;
                        n_res_last   = 1'b0;
                        n_res_status = STATUS_NOT_READY;
                        n_state      = S_EMIT;
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_ptr < cnt_m1 && r_thr > ram_rdata) begin
                    n_ptr   = r_ptr + AddrW'(1);
                    n_state = S_READ;
                end else begin
                    n_res_idx    = r_ptr;
                    n_res_last   = is_last;
                    n_res_status = STATUS_OK;
                    n_state      = S_EMIT;
                    if (is_last) begin
                        n_sum    = '0;
                        n_ld_cnt = '0;
                        n_dr_cnt = '0;
                        n_ptr    = '0;
                        n_thr    = '0;
                    end else begin
                        n_dr_cnt = r_dr_cnt + CntW'(1);
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = r_res_idx;
                    n_out_last   = r_res_last;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pcount    <= COUNT_RESET;
            r_stride    <= StrW'(STRIDE_RESET);
            r_sum       <= '0;
            r_ld_cnt    <= '0;
            r_dr_cnt    <= '0;
            r_ptr       <= '0;
            r_thr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pcount    <= n_pcount;
            r_stride    <= n_stride;
            r_sum       <= n_sum;
            r_ld_cnt    <= n_ld_cnt;
            r_dr_cnt    <= n_dr_cnt;
            r_ptr       <= n_ptr;
            r_thr       <= n_thr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_idx    <= n_res_idx;
        r_res_last   <= n_res_last;
        r_res_status <= n_res_status;
        r_out_idx    <= n_out_idx;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign idx_ext        = {{SOURCE_INDEX_W{1'b0}}, r_out_idx};
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_source_index = idx_ext[SOURCE_INDEX_W-1:0];
    assign o_last         = r_out_last;
    assign o_status       = r_out_status;

endmodule
`default_nettype wire

>>> hw/rtl/sysres_checker.sv
`default_nettype none
module sysres_checker #(
    parameter int MAX_PARTICLES = 1024
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_in_stall,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic [sysres_pkg::SOURCE_INDEX_W-1:0] o_source_index,
    input wire logic                              o_last,
    input wire logic                              o_status
);
    import sysres_pkg::*;

    localparam int MaxIdx = (MAX_PARTICLES > 1024) ? 1023 : MAX_PARTICLES - 1;

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_source_index) && $stable(o_last) && $stable(o_status))
        else $error("output changed while stalled");

    a_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STATUS_NOT_READY |-> o_source_index == '0 && !o_last)
        else $error("not-ready result carries index or last");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_source_index) <= 32'(MaxIdx))
        else $error("source index beyond particle range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("block not idle after reset");

endmodule

bind systematic_resampler_core sysres_checker #(
    .MAX_PARTICLES(MAX_PARTICLES)
) u_sysres_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_source_index(o_source_index),
    .o_last        (o_last),
    .o_status      (o_status)
);
`default_nettype wire
